>>> rtl/core/akf_pkg.sv
// ----------------------------------------------------------------------------
// akf_pkg
// Shared types, register indexes and fixed-point helpers of the angle filter.
// ----------------------------------------------------------------------------
package akf_pkg;

  localparam int unsigned NumAxes = 3;
  localparam int unsigned AxisW   = 2;
  localparam int unsigned AddrW   = (NumAxes > 1) ? $clog2(NumAxes) : 1;
  localparam int unsigned StateW  = 192;

  localparam logic [1:0] RegAngNoise  = 2'd0;
  localparam logic [1:0] RegBiasNoise = 2'd1;
  localparam logic [1:0] RegMeasNoise = 2'd2;
  localparam logic [1:0] RegPeriod    = 2'd3;

  localparam logic signed [31:0] Q30One = 32'sh4000_0000;

  typedef struct packed {
    logic signed [31:0] ang;
    logic signed [31:0] bias;
    logic signed [31:0] p00;
    logic signed [31:0] p01;
    logic signed [31:0] p10;
    logic signed [31:0] p11;
  } axis_state_t;

  typedef struct packed {
    logic              start;
    logic signed [31:0] num;
    logic signed [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic signed [31:0] quo;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return sat32(64'(a) + 64'(b));
  endfunction

  function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return sat32(64'(a) - 64'(b));
  endfunction

  // product already registered: round at bit 29, floor shift, saturate
  function automatic logic signed [31:0] rnd_q30(input logic signed [63:0] p);
    logic signed [63:0] r;
    r = (p + 64'sd536870912) >>> 30;
    return sat32(r);
  endfunction

endpackage

>>> rtl/core/akf_state_ram.sv
// ----------------------------------------------------------------------------
// akf_state_ram
// Per-axis filter state store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module akf_state_ram (
  input  logic                          clk_i,
  input  logic                          rd_en_i,
  input  logic [akf_pkg::AddrW-1:0]     rd_addr_i,
  output akf_pkg::axis_state_t          rd_data_o,
  input  logic                          wr_en_i,
  input  logic [akf_pkg::AddrW-1:0]     wr_addr_i,
  input  akf_pkg::axis_state_t          wr_data_i
);
  import akf_pkg::*;

  axis_state_t mem_q [NumAxes];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

>>> rtl/core/akf_divider.sv
// ----------------------------------------------------------------------------
// akf_divider
// Restoring divider for the gain: (|num| << 30) / den, one bit per cycle.
// ----------------------------------------------------------------------------
module akf_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  akf_pkg::div_req_t req_i,
  output akf_pkg::div_rsp_t rsp_o
);
  import akf_pkg::*;

  logic [61:0] quo_q, quo_d;
  logic [31:0] rem_q, rem_d;
  logic [30:0] den_q;
  logic        neg_q, busy_q, done_q;
  logic [5:0]  cnt_q;
  logic [32:0] trial;
  logic [62:0] q63;

  always_comb begin
    trial = {rem_q, quo_q[61]} - {2'b0, den_q};
    quo_d = {quo_q[60:0], ~trial[32]};
    rem_d = trial[32] ? {rem_q[30:0], quo_q[61]} : trial[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd62;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.num[31];
      quo_q <= {(req_i.num[31] ? 32'(-33'(req_i.num)) : 32'(req_i.num)), 30'd0};
      rem_q <= '0;
      den_q <= req_i.den[30:0];
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  always_comb begin
    q63 = {1'b0, quo_q};
    rsp_o.done = done_q;
    if (neg_q) begin
      rsp_o.quo = (q63 > 63'd2147483648) ? 32'sh8000_0000 : 32'(-64'(q63));
    end else begin
      rsp_o.quo = (q63 > 63'd2147483647) ? 32'sh7fff_ffff : quo_q[31:0];
    end
  end

endmodule

>>> rtl/core/angle_kalman_filter.sv
// ----------------------------------------------------------------------------
// angle_kalman_filter
// Three-axis angle and gyro-bias Kalman filter with per-axis state in memory.
// ----------------------------------------------------------------------------
// Sequence: with a positive innovation variance an item runs the prediction
// products, two gain divisions and the correction products; otherwise the
// divisions and corrections are skipped. A new item is taken only once the last
// is in the output register; the shared multiplier and divider set the pace.
// Reset: registers to defaults; a clearing pass writes the reset state to each
// axis entry, during which no item is taken.
module angle_kalman_filter (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [3:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                axis_i,
  input  logic signed [31:0]        measured_angle_i,
  input  logic signed [31:0]        gyro_rate_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                axis_out_o,
  output logic signed [31:0]        filtered_angle_o,
  output logic signed [31:0]        corrected_rate_o
);
  import akf_pkg::*;

  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_READ = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_DWT  = 7'b0100000,
    S_OUT  = 7'b1000000
  } fsm_e;

  fsm_e fsm_q;
  logic [30:0] r_q [4];
  logic [AddrW-1:0] clr_q, addr_q;
  logic signed [31:0] meas_q, rate_q;
  logic [1:0] axis_q;
  axis_state_t rd_st, st_q, wr_st;
  logic wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [4:0] step_q;
  logic signed [31:0] ma_q, mb_q, tmp_q, err_q, e_q, k0_q, k1_q;
  logic signed [63:0] prod_q;
  logic [1:0] ph_q;
  div_req_t dreq;
  div_rsp_t drsp;
  logic div_sel_q;
  logic out_v_q;
  logic signed [31:0] oa_q, or_q;
  logic [1:0] oax_q;
  logic signed [31:0] res;
  logic wr_cfg;

  assign pready = 1'b1;
  assign wr_cfg = psel && penable && pwrite;
  assign prdata = {1'b0, r_q[paddr[3:2]]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q[RegAngNoise]  <= 31'd1073742;
      r_q[RegBiasNoise] <= 31'd3221225;
      r_q[RegMeasNoise] <= 31'd536870912;
      r_q[RegPeriod]    <= 31'd10737418;
    end else if (wr_cfg) begin
      r_q[paddr[3:2]] <= pwdata[30:0];
    end
  end

  akf_state_ram u_ram (
    .clk_i, .rd_en_i(fsm_q == S_READ), .rd_addr_i(addr_q), .rd_data_o(rd_st),
    .wr_en_i(wr_en), .wr_addr_i(wr_addr), .wr_data_i(wr_st)
  );

  akf_divider u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  assign in_stall_o  = (fsm_q != S_IDLE);
  assign out_valid_o = out_v_q;
  assign axis_out_o  = oax_q;
  assign filtered_angle_o = oa_q;
  assign corrected_rate_o = or_q;

  assign res = rnd_q30(prod_q);

  always_comb begin
    dreq.start = 1'b0;
    dreq.num   = div_sel_q ? st_q.p10 : st_q.p00;
    dreq.den   = e_q;
    if (fsm_q == S_DIV) dreq.start = 1'b1;
    wr_en   = 1'b0;
    wr_addr = addr_q;
    wr_st   = st_q;
    if (fsm_q == S_CLR) begin
      wr_en   = 1'b1;
      wr_addr = clr_q;
      wr_st   = '{ang: '0, bias: '0, p00: Q30One, p01: '0, p10: '0, p11: Q30One};
    end else if (fsm_q == S_OUT && !(out_v_q && out_stall_i)) begin
      wr_en = 1'b1;
    end
  end

  // step sequence: prediction products 0..3, gain check 4, correction products 10..15
  // each step: operand load, product, accumulate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q    <= S_CLR;
      clr_q    <= '0;
      out_v_q  <= 1'b0;
      ph_q     <= '0;
      step_q   <= '0;
      div_sel_q <= 1'b0;
    end else begin
      if (fsm_q == S_OUT && !(out_v_q && out_stall_i)) begin
        out_v_q <= 1'b1;
      end else if (out_v_q && !out_stall_i) begin
        out_v_q <= 1'b0;
      end
      case (fsm_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AddrW'(NumAxes - 1)) fsm_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i && 32'(axis_i) < NumAxes) fsm_q <= S_READ;
        end
        S_READ: begin
          fsm_q <= S_MUL;
          step_q <= '0;
        end
        S_MUL: begin
          ph_q <= (ph_q == 2'd2) ? 2'd0 : ph_q + 2'd1;
          if (ph_q == 2'd2) begin
            if (step_q == 5'd4) begin
              if (e_q > 0) begin
                fsm_q <= S_DIV;
                div_sel_q <= 1'b0;
              end else begin
                step_q <= 5'd16;
                fsm_q  <= S_OUT;
              end
            end else begin
              step_q <= step_q + 5'd1;
              if (step_q == 5'd15) fsm_q <= S_OUT;
            end
          end
        end
        S_DIV: fsm_q <= S_DWT;
        S_DWT: begin
          if (drsp.done) begin
            if (!div_sel_q) begin
              div_sel_q <= 1'b1;
              fsm_q <= S_DIV;
            end else begin
              step_q <= 5'd10;
              fsm_q  <= S_MUL;
            end
          end
        end
        S_OUT: begin
          if (!(out_v_q && out_stall_i)) begin
            fsm_q   <= S_IDLE;
          end
        end
        default: fsm_q <= S_IDLE;
      endcase
    end
  end

  // datapath: operand select, one registered product, then accumulate
  always_ff @(posedge clk_i) begin
    case (fsm_q)
      S_IDLE: begin
        if (in_valid_i) begin
          addr_q <= axis_i[AddrW-1:0];
          axis_q <= axis_i;
          meas_q <= measured_angle_i;
          rate_q <= gyro_rate_i;
        end
      end
      S_READ: ;
      S_MUL: begin
        if (ph_q == 2'd0) begin
          if (step_q == 5'd0) st_q <= rd_st;
          case (step_q)
            5'd0: begin ma_q <= sub_sat(rate_q, rd_st.bias); mb_q <= 32'(r_q[RegPeriod]); end
            5'd1: begin
              ma_q <= sat32(64'($signed({1'b0, r_q[RegAngNoise]})) - 64'(st_q.p01)
                            - 64'(st_q.p10));
              mb_q <= 32'(r_q[RegPeriod]);
            end
            5'd2: begin ma_q <= sub_sat(32'sd0, st_q.p11); mb_q <= 32'(r_q[RegPeriod]); end
            5'd3: begin ma_q <= 32'(r_q[RegBiasNoise]); mb_q <= 32'(r_q[RegPeriod]); end
            5'd10: begin ma_q <= k0_q; mb_q <= st_q.p00; tmp_q <= st_q.p01; end
            5'd11: begin ma_q <= k0_q; mb_q <= tmp_q; tmp_q <= mb_q; end
            5'd12: begin ma_q <= k1_q; mb_q <= tmp_q; tmp_q <= mb_q; end
            5'd13: begin ma_q <= k1_q; mb_q <= tmp_q; end
            5'd14: begin ma_q <= k0_q; mb_q <= err_q; end
            5'd15: begin ma_q <= k1_q; mb_q <= err_q; end
            default: ;
          endcase
        end else if (ph_q == 2'd2) begin
          case (step_q)
            5'd0: begin
              st_q.ang <= add_sat(st_q.ang, res);
            end
            5'd1: st_q.p00 <= add_sat(st_q.p00, res);
            5'd2: begin
              st_q.p01 <= add_sat(st_q.p01, res);
              st_q.p10 <= add_sat(st_q.p10, res);
            end
            5'd3: begin
              st_q.p11 <= add_sat(st_q.p11, res);
              err_q <= sub_sat(meas_q, st_q.ang);
              e_q   <= add_sat(32'(r_q[RegMeasNoise]), st_q.p00);
            end
            5'd10: begin mb_q <= st_q.p00; st_q.p00 <= sub_sat(st_q.p00, res); end
            5'd11: st_q.p01 <= sub_sat(st_q.p01, res);
            5'd12: st_q.p10 <= sub_sat(st_q.p10, res);
            5'd13: st_q.p11 <= sub_sat(st_q.p11, res);
            5'd14: st_q.ang <= add_sat(st_q.ang, res);
            5'd15: st_q.bias <= add_sat(st_q.bias, res);
            default: ;
          endcase
        end
      end
      S_DWT: begin
        if (drsp.done) begin
          if (!div_sel_q) k0_q <= drsp.quo;
          else k1_q <= drsp.quo;
        end
      end
      S_OUT: begin
        if (!(out_v_q && out_stall_i)) begin
          oax_q <= axis_q;
          oa_q  <= st_q.ang;
          or_q  <= sub_sat(rate_q, st_q.bias);
        end
      end
      default: ;
    endcase
    if (fsm_q == S_MUL && ph_q == 2'd1) prod_q <= 64'(ma_q) * 64'(mb_q);
  end

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the three-axis angle/bias Kalman filter. A per-axis
// fixed-point predictor runs beside the block. Every result transfer is
// compared with the oldest expected one. The bench walks through several
// register settings, sends directed and random items, and uses random idling
// on both channels.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import akf_pkg::*;

  localparam int CycleLimit = 1500000;
  localparam int IdleTail   = 150;
  localparam int AngSpan    = 5898240;   // 90 degrees in Q16.16
  localparam int RateSpan   = 32768000;  // 500 deg/s in Q16.16

  typedef struct packed {
    logic [1:0]         axis;
    logic signed [31:0] angle;
    logic signed [31:0] rate;
  } filt_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] axis_i = '0;
  logic signed [31:0] measured_angle_i = '0;
  logic signed [31:0] gyro_rate_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] axis_out_o;
  logic signed [31:0] filtered_angle_o;
  logic signed [31:0] corrected_rate_o;

  angle_kalman_filter u_top (.*);

  initial forever #10 clk_i = ~clk_i;

  // predictor state
  logic [30:0] q_ang, q_bias, r_meas, dt_cfg;
  logic signed [31:0] m_ang [NumAxes];
  logic signed [31:0] m_bias[NumAxes];
  logic signed [31:0] m_p00 [NumAxes];
  logic signed [31:0] m_p01 [NumAxes];
  logic signed [31:0] m_p10 [NumAxes];
  logic signed [31:0] m_p11 [NumAxes];

  filt_res_t filt_exp_q[$];
  int mismatches = 0;
  int cycles = 0;
  int hold_left = 0;
  int stall_run = 0;
  bit no_gaps = 1'b0;

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] qmul(logic signed [31:0] a, logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    p = (p + 64'sd536870912) >>> 30;
    return clamp32(p);
  endfunction

  function automatic logic signed [31:0] qgain(logic signed [31:0] p, logic signed [31:0] e);
    longint unsigned num, q;
    bit neg;
    neg = p < 0;
    num = neg ? 64'(-longint'(p)) : 64'(longint'(p));
    num = num << 30;
    q = num / 64'(longint'(e));
    if (neg) begin
      if (q > 64'd2147483648) return 32'sh8000_0000;
      return clamp32(-longint'(q));
    end
    if (q > 64'd2147483647) return 32'sh7fff_ffff;
    return q[31:0];
  endfunction

  function automatic logic signed [31:0] sadd(logic signed [31:0] a, logic signed [31:0] b);
    return clamp32(longint'(a) + longint'(b));
  endfunction

  function automatic logic signed [31:0] ssub(logic signed [31:0] a, logic signed [31:0] b);
    return clamp32(longint'(a) - longint'(b));
  endfunction

  function automatic void reset_filter_model();
    q_ang  = 31'd1073742;
    q_bias = 31'd3221225;
    r_meas = 31'd536870912;
    dt_cfg = 31'd10737418;
    for (int i = 0; i < NumAxes; i++) begin
      m_ang[i] = '0; m_bias[i] = '0; m_p01[i] = '0; m_p10[i] = '0;
      m_p00[i] = Q30One; m_p11[i] = Q30One;
    end
  endfunction

  function automatic void predict_kalman(logic [1:0] a, logic signed [31:0] meas,
                                         logic signed [31:0] rate);
    logic signed [31:0] ang, bias, p00, p01, p10, p11, dt, d0, err, e, k0, k1, t0, t1;
    filt_res_t r;
    if (a >= NumAxes) return;
    dt = {1'b0, dt_cfg};
    ang = m_ang[a]; bias = m_bias[a];
    p00 = m_p00[a]; p01 = m_p01[a]; p10 = m_p10[a]; p11 = m_p11[a];
    ang = sadd(ang, qmul(ssub(rate, bias), dt));
    d0  = clamp32(longint'({1'b0, q_ang}) - longint'(p01) - longint'(p10));
    p00 = sadd(p00, qmul(d0, dt));
    p01 = sadd(p01, qmul(ssub(0, p11), dt));
    p10 = sadd(p10, qmul(ssub(0, p11), dt));
    p11 = sadd(p11, qmul({1'b0, q_bias}, dt));
    err = ssub(meas, ang);
    e   = sadd({1'b0, r_meas}, p00);
    if (e > 0) begin
      k0 = qgain(p00, e);
      k1 = qgain(p10, e);
    end else begin
      k0 = '0;
      k1 = '0;
    end
    t0 = p00; t1 = p01;
    p00 = ssub(p00, qmul(k0, t0));
    p01 = ssub(p01, qmul(k0, t1));
    p10 = ssub(p10, qmul(k1, t0));
    p11 = ssub(p11, qmul(k1, t1));
    ang  = sadd(ang, qmul(k0, err));
    bias = sadd(bias, qmul(k1, err));
    m_ang[a] = ang; m_bias[a] = bias;
    m_p00[a] = p00; m_p01[a] = p01; m_p10[a] = p10; m_p11[a] = p11;
    r.axis = a; r.angle = ang; r.rate = ssub(rate, bias);
    filt_exp_q.push_back(r);
  endfunction

  // cycle limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (stall_run > 0) begin
      stall_run--;
    end else if (no_gaps) begin
      out_stall_i <= 1'b0;
    end else if ($urandom_range(0, 2) == 0) begin
      out_stall_i <= 1'b1;
      stall_run = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
    end else begin
      out_stall_i <= 1'b0;
      stall_run = $urandom_range(0, 40);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    filt_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (filt_exp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transfer: axis %0d angle %0d rate %0d",
                   axis_out_o, filtered_angle_o, corrected_rate_o);
      end else begin
        want = filt_exp_q.pop_front();
        if (axis_out_o !== want.axis || filtered_angle_o !== want.angle ||
            corrected_rate_o !== want.rate) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: exp axis %0d angle %0d rate %0d, got %0d %0d %0d",
                     want.axis, want.angle, want.rate,
                     axis_out_o, filtered_angle_o, corrected_rate_o);
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      RegAngNoise:  q_ang  = val[30:0];
      RegBiasNoise: q_bias = val[30:0];
      RegMeasNoise: r_meas = val[30:0];
      default:      dt_cfg = val[30:0];
    endcase
  endtask

  task automatic set_regs(logic [31:0] qa, logic [31:0] qb, logic [31:0] rm, logic [31:0] dt);
    write_reg(RegAngNoise, qa);
    write_reg(RegBiasNoise, qb);
    write_reg(RegMeasNoise, rm);
    write_reg(RegPeriod, dt);
  endtask

  // one input transfer; valid is left high only when another send follows at once
  task automatic send_item(logic [1:0] a, logic signed [31:0] meas, logic signed [31:0] rate);
    int g;
    in_valid_i <= 1'b1;
    axis_i <= a; measured_angle_i <= meas; gyro_rate_i <= rate;
    do @(posedge clk_i); while (in_stall_o);
    predict_kalman(a, meas, rate);
    if (no_gaps) g = 0;
    else if ($urandom_range(0, 9) < 7) g = $urandom_range(0, 2);
    else if ($urandom_range(0, 3) != 0) g = $urandom_range(3, 8);
    else g = $urandom_range(20, 80);
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (filt_exp_q.size() != 0) @(posedge clk_i);
    repeat (IdleTail) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] pick_val(int span);
    if ($urandom_range(0, 3) != 0) return $urandom_range(0, 2 * span) - span;
    return $urandom;
  endfunction

  task automatic send_random(int count);
    logic [1:0] a;
    int sent;
    sent = 0;
    while (sent < count) begin
      a = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      if (a < NumAxes) sent++;
      send_item(a, pick_val(AngSpan), pick_val(RateSpan));
    end
  endtask

  task automatic test_directed();
    send_item(2'd0, 32'sd0, 32'sd0);
    send_item(2'd1, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_item(2'd2, 32'sh8000_0000, 32'sh8000_0000);
    send_item(2'd3, 32'sh7fff_ffff, 32'sh8000_0000);
    send_item(2'd0, 32'sh7fff_ffff, 32'sh8000_0000);
    send_item(2'd1, 32'sh8000_0000, 32'sh7fff_ffff);
    send_item(2'd2, 32'shffff_ffff, 32'sh0000_0001);
    send_item(2'd3, 32'sd0, 32'sd0);
    send_item(2'd0, 32'sd2949120, -32'sd655360);
    send_item(2'd1, -32'sd2949120, 32'sd655360);
    send_item(2'd2, 32'sh5555_5555, 32'shaaaa_aaaa);
    send_item(2'd0, 32'shaaaa_aaaa, 32'sh5555_5555);
    drain();
  endtask

  task automatic test_defaults();
    send_random(150);
    drain();
  endtask

  task automatic test_reg_extremes();
    set_regs(32'd0, 32'd0, 32'd1, 32'd1);
    send_random(80);
    drain();
    set_regs(32'd1073741824, 32'd1073741824, 32'd2147483647, 32'd1073741824);
    send_item(2'd0, 32'sh7fff_ffff, 32'sh8000_0000);
    send_item(2'd1, 32'sh8000_0000, 32'sh7fff_ffff);
    send_random(80);
    drain();
    // bit 31 of the write data is dropped by the register
    set_regs(32'hffff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'hc000_0000);
    send_random(60);
    drain();
    set_regs(32'd0, 32'd1073741824, 32'd1, 32'd1073741824);
    send_random(60);
    drain();
  endtask

  task automatic test_reg_random();
    for (int i = 0; i < 4; i++) begin
      set_regs($urandom_range(0, 1073741824), $urandom_range(0, 1073741824),
               $urandom_range(1, 2147483647), $urandom_range(1, 1073741824));
      send_random(60);
      drain();
    end
    set_regs(32'd1073742, 32'd3221225, 32'd536870912, 32'd10737418);
  endtask

  task automatic test_back_pressure();
    hold_left = 2500;
    no_gaps = 1'b1;
    send_random(30);
    no_gaps = 1'b0;
    drain();
  endtask

  task automatic test_no_idle();
    no_gaps = 1'b1;
    send_random(100);
    no_gaps = 1'b0;
    drain();
  endtask

  task automatic test_mixed();
    send_random(160);
    drain();
  endtask

  initial begin
    reset_filter_model();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_defaults();
    test_reg_extremes();
    test_reg_random();
    test_back_pressure();
    test_no_idle();
    test_mixed();
    if (mismatches == 0 && filt_exp_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
